/* design/espg_pkg.sv */
// Package for the encoder servo pulse generator.
// Holds register indexes, reset values and the configuration struct; no dependencies.
`default_nettype none
package espg_pkg;

  localparam int ACCUM_BITS_DEF = 24;
  localparam int REG_IDX_BITS   = 2;
  localparam int REG_DATA_BITS  = 15;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_PERIOD_TICKS    = 2'd0,
    REG_MIN_PULSE_TICKS = 2'd1,
    REG_MAX_POSITION    = 2'd2,
    REG_STEP_SIZE       = 2'd3
  } reg_idx_t;

  localparam logic [14:0] PERIOD_TICKS_RST    = 15'd20000;
  localparam logic [14:0] MIN_PULSE_TICKS_RST = 15'd1050;
  localparam logic [14:0] MAX_POSITION_RST    = 15'd1000;
  localparam logic [9:0]  STEP_SIZE_RST       = 10'd50;

  typedef struct packed {
    logic [14:0] period_ticks;
    logic [14:0] min_pulse_ticks;
    logic [14:0] max_position;
    logic [9:0]  step_size;
  } cfg_t;

endpackage
`default_nettype wire

/* design/espg_cfg.sv */
// Configuration register file for the encoder servo pulse generator.
// Depends on espg_pkg for register indexes, reset values and cfg_t.
`default_nettype none
module espg_cfg
  import espg_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [REG_IDX_BITS-1:0]  wr_index,
  input  wire logic [REG_DATA_BITS-1:0] wr_data,
  output cfg_t                          cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_ticks    <= PERIOD_TICKS_RST;
      cfg.min_pulse_ticks <= MIN_PULSE_TICKS_RST;
      cfg.max_position    <= MAX_POSITION_RST;
      cfg.step_size       <= STEP_SIZE_RST;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_PERIOD_TICKS:    cfg.period_ticks    <= wr_data;
        REG_MIN_PULSE_TICKS: cfg.min_pulse_ticks <= wr_data;
        REG_MAX_POSITION:    cfg.max_position    <= wr_data;
        REG_STEP_SIZE:       cfg.step_size       <= wr_data[9:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/espg_core.sv */
// Per-tick state update: frame counter, encoder accumulator and position commit.
// Depends on espg_pkg for cfg_t.
`default_nettype none
module espg_core
  import espg_pkg::*;
#(
  parameter int ACCUM_BITS = ACCUM_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        take,
  input  wire logic        enc_a,
  input  wire logic        enc_b,
  output logic             pulse_out,
  output logic [14:0]      position
);

  logic [14:0]                  tick_count;
  logic [14:0]                  committed_position;
  logic signed [ACCUM_BITS-1:0] accumulator;
  logic                         last_a;

  logic [15:0]                  threshold;
  logic                         high;
  logic                         frame_end;
  logic signed [ACCUM_BITS:0]   step_ext;
  logic signed [ACCUM_BITS:0]   sum;
  logic signed [ACCUM_BITS-1:0] acc_mid;
  logic [14:0]                  clamped;
  logic [14:0]                  tick_count_next;
  logic signed [ACCUM_BITS-1:0] accumulator_next;
  logic [14:0]                  committed_position_next;
  logic                         last_a_next;

  assign threshold = {1'b0, cfg.min_pulse_ticks} + {1'b0, committed_position};
  assign high      = {1'b0, tick_count} < threshold;
  assign frame_end = ({1'b0, tick_count} + 16'd1) >= {1'b0, cfg.period_ticks};
  assign step_ext  = $signed({{(ACCUM_BITS-9){1'b0}}, cfg.step_size});

  assign pulse_out = high;
  assign position  = committed_position;

  always_comb begin
    sum = (enc_b != enc_a) ? ({accumulator[ACCUM_BITS-1], accumulator} - step_ext)
                           : ({accumulator[ACCUM_BITS-1], accumulator} + step_ext);
    acc_mid     = accumulator;
    last_a_next = last_a;
    if (!high) begin
      last_a_next = enc_a;
      if (enc_a != last_a) begin
        if (sum[ACCUM_BITS] != sum[ACCUM_BITS-1]) begin
          acc_mid = sum[ACCUM_BITS] ? {1'b1, {(ACCUM_BITS-1){1'b0}}}
                                    : {1'b0, {(ACCUM_BITS-1){1'b1}}};
        end else begin
          acc_mid = sum[ACCUM_BITS-1:0];
        end
      end
    end

    if (acc_mid[ACCUM_BITS-1]) begin
      clamped = 15'd0;
    end else if (acc_mid[ACCUM_BITS-2:0] > {{(ACCUM_BITS-16){1'b0}}, cfg.max_position}) begin
      clamped = cfg.max_position;
    end else begin
      clamped = acc_mid[14:0];
    end

    if (frame_end) begin
      accumulator_next        = $signed({{(ACCUM_BITS-15){1'b0}}, clamped});
      committed_position_next = clamped;
      tick_count_next         = 15'd0;
    end else begin
      accumulator_next        = acc_mid;
      committed_position_next = committed_position;
      tick_count_next         = tick_count + 15'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count         <= 15'd0;
      committed_position <= 15'd0;
      accumulator        <= '0;
      last_a             <= 1'b0;
    end else if (take) begin
      tick_count         <= tick_count_next;
      committed_position <= committed_position_next;
      accumulator        <= accumulator_next;
      last_a             <= last_a_next;
    end
  end

endmodule
`default_nettype wire

/* design/encoder_servo_pulse_generator_top.sv */
// Top level of the encoder servo pulse generator: config registers, tick core, result register.
// Depends on espg_pkg, espg_cfg and espg_core.
//
// Usage:
//   Each input transaction (in_valid/in_ready, enc_a, enc_b) is one timer tick.
//   Each tick yields exactly one result transaction (out_valid/out_ready,
//   pulse_out, position), registered when the tick is accepted.
//   Throughput is one tick per cycle while the receiver keeps up: the core updates
//   its frame counter, accumulator and committed position in one pass, and the result
//   register takes a new result whenever it is empty or being drained in the same cycle.
//   When the receiver stalls, the result holds in the output register and
//   in_ready drops until it is taken; no result is lost.
//   Configuration writes (wr_en, wr_index, wr_data) take effect at the clock
//   edge; write only while no tick is in flight. Unknown indexes are ignored.
//   Reset (rst, synchronous, active high) loads the default register values,
//   clears the frame counter, accumulator, committed position and last A
//   sample, and empties the output register.
`default_nettype none
module encoder_servo_pulse_generator_top
  import espg_pkg::*;
#(
  parameter int ACCUM_BITS = ACCUM_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [REG_IDX_BITS-1:0]  wr_index,
  input  wire logic [REG_DATA_BITS-1:0] wr_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     enc_a,
  input  wire logic                     enc_b,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          pulse_out,
  output logic [14:0]                   position
);

  cfg_t        cfg;
  logic        take;
  logic        core_pulse;
  logic [14:0] core_position;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  espg_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  espg_core #(
    .ACCUM_BITS (ACCUM_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .enc_a     (enc_a),
    .enc_b     (enc_b),
    .pulse_out (core_pulse),
    .position  (core_position)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pulse_out <= core_pulse;
      position  <= core_position;
    end
  end

endmodule
`default_nettype wire
